/* design/tma_pkg.sv */
// ----------------------------------------------------------------------------
// tma_pkg: shared definitions for the thresholded moving average
// Register indexes, fixed field widths, reset values and the divider status.
// ----------------------------------------------------------------------------
package tma_pkg;

  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int WS_W       = 6;
  localparam int MIN_DIST_W = 12;
  localparam int MEAN_W     = 20;
  localparam int FRAC_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 1'b1;

  localparam logic [WS_W-1:0]       WS_RESET       = 6'd8;
  localparam logic [MIN_DIST_W-1:0] MIN_DIST_RESET = 12'd20;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* design/tma_div.sv */
// ----------------------------------------------------------------------------
// tma_div: bit-serial restoring divider
// Produces one quotient bit per cycle. The caller preloads the upper part of
// the dividend as the partial remainder, which must already be below the divisor.
// ----------------------------------------------------------------------------
module tma_div #(
  parameter int DVS_W = 6,
  parameter int QW    = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DVS_W-1:0]     rem_init,
  input  logic [QW-1:0]        dividend_lo,
  input  logic [DVS_W-1:0]     divisor,
  output logic [QW-1:0]        quotient,
  output tma_pkg::div_stat_t   stat
);
  import tma_pkg::*;

  localparam int CNT_W = $clog2(QW);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [QW-1:0]    sh_r, sh_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic             fits;
  div_stat_t        stat_w;

  assign trial = {rem_r, sh_r[QW-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = rem_init;
      sh_nxt   = dividend_lo;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Dividend bits leave at the top while quotient bits enter at the bottom.
      if (fits) begin
        rem_nxt = DVS_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[DVS_W-1:0];
      end
      sh_nxt  = {sh_r[QW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign stat_w.busy = busy_r;
  assign stat_w.done = done_r;
  assign stat       = stat_w;
  assign quotient   = sh_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start) |-> (rem_r < divisor))
    else $error("partial remainder not below divisor");

endmodule

/* design/thresholded_moving_average.sv */
// ----------------------------------------------------------------------------
// thresholded_moving_average: windowed mean of distance samples with abort
// An accepted sample passes the update state, the bit-serial divider and the done state
// before out_valid rises; a too-close sample goes from acceptance straight to the done state.
// A new sample is taken only after the last result has left the done state;
// in_ready is high only when idle, so a result stalled by out_ready holds it low.
// Synchronous reset empties the window and loads window_size 8, min_distance 20.
// ----------------------------------------------------------------------------
module thresholded_moving_average #(
  parameter int MAX_WINDOW  = 32,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SAMPLE_BITS-1:0]            in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tma_pkg::MEAN_W-1:0]        out_mean_q8,
  output logic                              out_too_close,
  output logic                              out_window_full,
  input  logic                              cfg_we,
  input  logic [tma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tma_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tma_pkg::*;

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + PTR_W;
  localparam int QW     = SAMPLE_BITS + FRAC_W;
  localparam int WCMP_W = (CNT_W > WS_W) ? CNT_W : WS_W;
  localparam int CMP_W  = (SAMPLE_BITS > MIN_DIST_W) ? SAMPLE_BITS : MIN_DIST_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  logic [2:0]            state_r, state_nxt;
  logic [WS_W-1:0]       ws_r, ws_nxt;
  logic [MIN_DIST_W-1:0] min_r, min_nxt;
  logic [PTR_W-1:0]      ptr_r, ptr_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  close_r, close_nxt;
  logic                  full_r, full_nxt;
  logic [MEAN_W-1:0]     mean_r, mean_nxt;
  logic                  out_close_r, out_close_nxt;
  logic                  out_full_r, out_full_nxt;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0] rd_data_r;

  logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];

  logic [WCMP_W-1:0] ws_ext;
  logic [CNT_W-1:0]  w_eff;
  logic [PTR_W-1:0]  slot;
  logic [CNT_W-1:0]  slot_inc;
  logic              in_fire;
  logic              too_close_in;
  logic              full_now;
  logic [SUM_W-1:0]  sum_upd;
  logic [CNT_W-1:0]  fill_upd;
  logic [PTR_W-1:0]  ptr_upd;
  logic              div_start;
  logic [QW-1:0]     quot;
  div_stat_t         div_stat;

  // Window size zero counts as one; sizes above the ring depth saturate.
  always_comb begin
    ws_ext = WCMP_W'(ws_r);
    if (ws_ext == '0) begin
      w_eff = CNT_W'(1);
    end else if (ws_ext > WCMP_W'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(ws_ext);
    end
  end

  assign slot     = (CNT_W'(ptr_r) >= w_eff) ? '0 : ptr_r;
  assign slot_inc = CNT_W'(slot) + 1'b1;
  assign ptr_upd  = (slot_inc >= w_eff) ? '0 : PTR_W'(slot_inc);

  assign in_ready     = (state_r == ST_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign too_close_in = (CMP_W'(in_sample) < CMP_W'(min_r));

  assign full_now = (fill_r >= w_eff);
  assign sum_upd  = sum_r - (full_now ? SUM_W'(rd_data_r) : '0) + SUM_W'(sample_r);
  assign fill_upd = full_now ? fill_r : fill_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    ws_nxt        = ws_r;
    min_nxt       = min_r;
    ptr_nxt       = ptr_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    close_nxt     = close_r;
    full_nxt      = full_r;
    mean_nxt      = mean_r;
    out_close_nxt = out_close_r;
    out_full_nxt  = out_full_r;
    div_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (too_close_in) begin
            ptr_nxt   = '0;
            fill_nxt  = '0;
            sum_nxt   = '0;
            close_nxt = 1'b1;
            full_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            close_nxt = 1'b0;
            state_nxt = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        sum_nxt   = sum_upd;
        fill_nxt  = fill_upd;
        ptr_nxt   = ptr_upd;
        full_nxt  = (fill_upd == w_eff);
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // The result is loaded once the output register is empty or being read.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          mean_nxt      = close_r ? '0 : MEAN_W'(quot);
          out_close_nxt = close_r;
          out_full_nxt  = full_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE: begin
          ws_nxt   = cfg_data[WS_W-1:0];
          ptr_nxt  = '0;
          fill_nxt = '0;
          sum_nxt  = '0;
        end
        CFG_MIN_DISTANCE: begin
          min_nxt = cfg_data[MIN_DIST_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ws_r        <= WS_RESET;
      min_r       <= MIN_DIST_RESET;
      ptr_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      close_r     <= 1'b0;
      full_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ws_r        <= ws_nxt;
      min_r       <= min_nxt;
      ptr_r       <= ptr_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      close_r     <= close_nxt;
      full_r      <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mean_r      <= mean_nxt;
    out_close_r <= out_close_nxt;
    out_full_r  <= out_full_nxt;
    if (in_fire) begin
      sample_r <= in_sample;
    end
  end

  // Sample ring: the oldest entry is read at acceptance, the new one written
  // back to the same slot in the next cycle, from the update state.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= ring[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) begin
      ring[slot] <= sample_r;
    end
  end

  // The sum stays below fill times 2^SAMPLE_BITS, so its upper bits already
  // form a partial remainder smaller than the divisor.
  tma_div #(
    .DVS_W (CNT_W),
    .QW    (QW)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .rem_init    (CNT_W'(sum_upd[SUM_W-1:SAMPLE_BITS])),
    .dividend_lo ({sum_upd[SAMPLE_BITS-1:0], {FRAC_W{1'b0}}}),
    .divisor     (fill_r),
    .quotient    (quot),
    .stat        (div_stat)
  );

  assign out_valid       = out_valid_r;
  assign out_mean_q8     = mean_r;
  assign out_too_close   = out_close_r;
  assign out_window_full = out_full_r;

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (sum_r == '0))
    else $error("empty window with nonzero sum");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_WINDOW))
    else $error("fill count beyond ring depth");

  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");

endmodule
